// ===== sv/bos_pkg.sv =====
`timescale 1ns / 1ps
// Package of shared types, constants and register indexes for overlap suppression.
package bos_pkg;

  localparam int CfgW = 16;
  localparam logic [CfgW-1:0] CFG_THRESHOLD = 16'd0;
  localparam logic [CfgW-1:0] CFG_MODE      = 16'd1;
  localparam logic [15:0] THRESHOLD_RESET   = 16'd29491;

  typedef struct packed {
    logic        first;
    logic [15:0] x;
    logic [15:0] y;
    logic [14:0] w;
    logic [14:0] h;
    logic [15:0] score;
  } box_t;

  // Stored box: x, y, w, h packed as in the table.
  typedef struct packed {
    logic [1:0]  pad;
    logic [14:0] h;
    logic [14:0] w;
    logic [15:0] y;
    logic [15:0] x;
  } entry_t;

endpackage

// ===== sv/bos_ram.sv =====
`timescale 1ns / 1ps
// Generic single-port-write, single-read RAM with registered read data.
module bos_ram #(
  parameter int Width = 64,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(Depth)-1:0] wr_addr,
  input  logic [Width-1:0]         wr_data,
  input  logic [$clog2(Depth)-1:0] rd_addr,
  output logic [Width-1:0]         rd_data
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule

// ===== sv/bos_front.sv =====
`timescale 1ns / 1ps
// Input side: a two-entry queue of words that decouples intake from the compare engine.
module bos_front import bos_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  box_t in_box,
  output logic q_valid,
  input  logic q_take,
  output box_t q_box
);
  box_t       slot_r [2];
  logic       rd_ptr_r, wr_ptr_r;
  logic [1:0] cnt_r;
  logic       push;

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_box    = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= in_box;
    end
    if (!rst_n) begin
      rd_ptr_r <= 1'b0;
      wr_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (q_take) rd_ptr_r <= !rd_ptr_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_take};
    end
  end
endmodule

// ===== sv/bos_back.sv =====
`timescale 1ns / 1ps
// Compare engine: one stored box per cycle through a pipelined overlap test.
module bos_back import bos_pkg::*; #(
  parameter int MaxKept = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [15:0] threshold,
  input  logic        mode,
  input  logic        q_valid,
  output logic        q_take,
  input  box_t        q_box,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_kept,
  output logic        out_overflow,
  output box_t        out_box
);
  localparam int AW = (MaxKept > 1) ? $clog2(MaxKept) : 1;
  localparam int CW = $clog2(MaxKept + 1);
  localparam logic [CW-1:0] FULL = CW'(MaxKept);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_DONE = 3'd3;

  logic [2:0]    state_r;
  box_t          cur_r;
  logic [CW-1:0] count_r, idx_r, limit_r;
  logic          hit_r;
  // Pipe valids: ram read, stage 1 (extents), stage 2 (products), stage 3 (compare).
  logic [3:0]    pv_r;
  logic          ov_r, okept_r, oovf_r;
  logic          ov_nxt;
  logic          issue;
  box_t          obox_r;

  entry_t        rd_e;
  logic [63:0]   rd_data;
  logic          wr_en;
  logic [AW-1:0] rd_addr;

  assign rd_e = entry_t'(rd_data);
  assign rd_addr = idx_r[AW-1:0];

  bos_ram #(.Width(64), .Depth(MaxKept)) u_ram (
    .clk(clk), .wr_en(wr_en), .wr_addr(count_r[AW-1:0]),
    .wr_data({2'b00, cur_r.h, cur_r.w, cur_r.y, cur_r.x}),
    .rd_addr(rd_addr), .rd_data(rd_data)
  );

  // Stage 1: per-axis overlap extents.
  logic signed [17:0] ax1, ax2, bx1, bx2, ay1, ay2, by1, by2, dx, dy;
  logic signed [17:0] dx_r, dy_r;
  logic [14:0] kw_r, kh_r;
  always_comb begin
    ax1 = 18'(signed'(rd_e.x));
    ay1 = 18'(signed'(rd_e.y));
    ax2 = ax1 + 18'(signed'({1'b0, rd_e.w}));
    ay2 = ay1 + 18'(signed'({1'b0, rd_e.h}));
    bx1 = 18'(signed'(cur_r.x));
    by1 = 18'(signed'(cur_r.y));
    bx2 = bx1 + 18'(signed'({1'b0, cur_r.w}));
    by2 = by1 + 18'(signed'({1'b0, cur_r.h}));
    dx = ((ax2 < bx2) ? ax2 : bx2) - ((ax1 > bx1) ? ax1 : bx1) + 18'sd1;
    dy = ((ay2 < by2) ? ay2 : by2) - ((ay1 > by1) ? ay1 : by1) + 18'sd1;
  end

  // Stage 2: intersection and the two areas.
  logic [33:0] inter_r;
  logic [29:0] aa_r, ab_r;
  logic [16:0] ux, uy;
  always_comb begin
    ux = dx_r[17] ? 17'd0 : dx_r[16:0];
    uy = dy_r[17] ? 17'd0 : dy_r[16:0];
  end

  // Stage 3: denominator; the threshold product and compare are combinational on its register.
  logic signed [34:0] den;
  logic signed [34:0] den_r;
  logic [33:0] inter2_r;
  always_comb begin
    if (!mode) begin
      den = 35'(aa_r) + 35'(ab_r) - 35'(inter_r);
    end else begin
      den = 35'((aa_r < ab_r) ? aa_r : ab_r);
    end
  end
  logic [49:0] lhs;
  logic [50:0] rhs;
  logic        ovl;
  assign lhs = {inter2_r, 16'd0};
  assign rhs = 51'(den_r[33:0]) * 51'(threshold);
  assign ovl = (den_r <= 0) || (51'(lhs) > rhs);

  logic out_free;
  assign out_free = !ov_r || !out_stall;
  assign q_take = (state_r == S_IDLE) && q_valid;
  assign wr_en  = (state_r == S_DONE) && out_free && !hit_r && (count_r != FULL);
  assign issue  = (state_r == S_SCAN) && (idx_r != limit_r);

  always_comb begin
    ov_nxt = ov_r;
    if (ov_r && !out_stall) ov_nxt = 1'b0;
    if ((state_r == S_DONE) && out_free) ov_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    dx_r <= dx;
    dy_r <= dy;
    kw_r <= rd_e.w;
    kh_r <= rd_e.h;
    inter_r <= 34'(ux) * 34'(uy);
    aa_r <= 30'(kw_r) * 30'(kh_r);
    ab_r <= 30'(cur_r.w) * 30'(cur_r.h);
    inter2_r <= inter_r;
    den_r <= den;
    if (q_take) cur_r <= q_box;
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      idx_r   <= '0;
      limit_r <= '0;
      hit_r   <= 1'b0;
      pv_r    <= '0;
      ov_r    <= 1'b0;
    end else begin
      pv_r <= {pv_r[2:0], issue};
      ov_r <= ov_nxt;
      case (state_r)
        S_IDLE: begin
          if (q_take) begin
            idx_r   <= '0;
            hit_r   <= 1'b0;
            limit_r <= q_box.first ? '0 : count_r;
            if (q_box.first) count_r <= '0;
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (idx_r == limit_r) begin
            state_r <= S_DRAIN;
          end else begin
            idx_r   <= idx_r + 1'b1;
          end
        end
        S_DRAIN: begin
          if (pv_r == 4'd0) state_r <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            okept_r <= !hit_r;
            oovf_r  <= !hit_r && (count_r == FULL);
            obox_r  <= cur_r;
            if (wr_en) count_r <= count_r + 1'b1;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
      if (pv_r[3] && ovl) hit_r <= 1'b1;
    end
  end

  assign out_valid    = ov_r;
  assign out_kept     = okept_r;
  assign out_overflow = oovf_r;
  assign out_box      = obox_r;
endmodule

// ===== sv/box_overlap_suppression.sv =====
`timescale 1ns / 1ps
// Top level of greedy overlap suppression over a table of kept boxes.
// For each word the compare engine reads the kept boxes one per cycle from the table RAM;
// a two-word queue takes input meanwhile, and a stalled result holds the engine.
// Synchronous active-low reset empties the table and loads register defaults.
module box_overlap_suppression import bos_pkg::*; #(
  parameter int MaxKept = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_index,
  input  logic [15:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_first_of_set,
  input  logic [15:0] in_box_x,
  input  logic [15:0] in_box_y,
  input  logic [14:0] in_box_w,
  input  logic [14:0] in_box_h,
  input  logic [15:0] in_box_score,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_kept,
  output logic [15:0] out_out_x,
  output logic [15:0] out_out_y,
  output logic [14:0] out_out_w,
  output logic [14:0] out_out_h,
  output logic [15:0] out_out_score,
  output logic        out_table_overflow
);
  logic [15:0] threshold_r;
  logic        mode_r;
  box_t        in_box, q_box, o_box;
  logic        q_valid, q_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= THRESHOLD_RESET;
      mode_r      <= 1'b0;
    end else if (cfg_wr_en) begin
      if (cfg_index == CFG_THRESHOLD) threshold_r <= cfg_wr_data;
      if (cfg_index == CFG_MODE) mode_r <= cfg_wr_data[0];
    end
  end

  assign in_box = '{first: in_first_of_set, x: in_box_x, y: in_box_y,
                    w: in_box_w, h: in_box_h, score: in_box_score};

  bos_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_box(in_box), .q_valid(q_valid), .q_take(q_take), .q_box(q_box)
  );

  bos_back #(.MaxKept(MaxKept)) u_back (
    .clk(clk), .rst_n(rst_n), .threshold(threshold_r), .mode(mode_r),
    .q_valid(q_valid), .q_take(q_take), .q_box(q_box),
    .out_valid(out_valid), .out_stall(out_stall), .out_kept(out_kept),
    .out_overflow(out_table_overflow), .out_box(o_box)
  );

  assign out_out_x     = o_box.x;
  assign out_out_y     = o_box.y;
  assign out_out_w     = o_box.w;
  assign out_out_h     = o_box.h;
  assign out_out_score = o_box.score;
endmodule
